/* design/its_pkg.sv */
// ----------------------------------------------------------------------------
// its_pkg: shared types and constants of the integer to radix string block
// Holds the controller state encoding, the command/status bundles between
// controller and datapath, and the character codes used by the load checks.
// ----------------------------------------------------------------------------
package its_pkg;

    localparam int LEN_W       = 8;   // alphabet length, 0..128
    localparam int CHAR_W      = 7;
    localparam int DIGIT_DEPTH = 32;  // digit buffer entries
    localparam int BUF_AW      = 5;
    localparam int ND_W        = 6;   // digit count, 0..32
    localparam int DIV_STEPS   = 8;   // quotient bits resolved per cycle

    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_DEL   = 8'd127;

    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_CONVERT = 1'b1;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_LOAD  = 8'b0000_0010,
        ST_ERR   = 8'b0000_0100,
        ST_DIV   = 8'b0000_1000,
        ST_LOOK  = 8'b0001_0000,
        ST_STORE = 8'b0010_0000,
        ST_SIGN  = 8'b0100_0000,
        ST_EMIT  = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic accept;      // capture the input beat
        logic load;        // check and store one alphabet character
        logic div_step;    // one pass of the radix divider
        logic store;       // write the looked-up digit to the buffer
        logic emit_sign;
        logic emit_digit;
        logic emit_err;
    } cmd_t;

    typedef struct packed {
        logic alph_valid;
        logic div_last;    // current pass finishes the quotient
        logic digits_done; // quotient zero or buffer full
        logic neg;
        logic out_free;    // output register can take a beat
        logic emit_last;   // next digit out is the final one
    } sts_t;

endpackage

/* design/its_ctrl.sv */
// ----------------------------------------------------------------------------
// its_ctrl: sequencing state machine
// Accepts input beats, steps the datapath through alphabet load, digit
// extraction and the emission of characters or of an error beat.
// ----------------------------------------------------------------------------
module its_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    input  logic          s_tuser,
    output logic          s_tready,
    input  its_pkg::sts_t sts,
    output its_pkg::cmd_t cmd
);

    its_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= its_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == its_pkg::ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            its_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    if (s_tuser == its_pkg::REQ_LOAD) begin
                        state_next = its_pkg::ST_LOAD;
                    end else if (sts.alph_valid) begin
                        state_next = its_pkg::ST_DIV;
                    end else begin
                        state_next = its_pkg::ST_ERR;
                    end
                end
            end
            its_pkg::ST_LOAD: begin
                cmd.load   = 1'b1;
                state_next = its_pkg::ST_IDLE;
            end
            its_pkg::ST_ERR: begin
                if (sts.out_free) begin
                    cmd.emit_err = 1'b1;
                    state_next   = its_pkg::ST_IDLE;
                end
            end
            its_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = its_pkg::ST_LOOK;
                end
            end
            // table read of the remainder is in flight
            its_pkg::ST_LOOK: begin
                state_next = its_pkg::ST_STORE;
            end
            its_pkg::ST_STORE: begin
                cmd.store = 1'b1;
                if (!sts.digits_done) begin
                    state_next = its_pkg::ST_DIV;
                end else if (sts.neg) begin
                    state_next = its_pkg::ST_SIGN;
                end else begin
                    state_next = its_pkg::ST_EMIT;
                end
            end
            its_pkg::ST_SIGN: begin
                if (sts.out_free) begin
                    cmd.emit_sign = 1'b1;
                    state_next    = its_pkg::ST_EMIT;
                end
            end
            its_pkg::ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit_digit = 1'b1;
                    if (sts.emit_last) begin
                        state_next = its_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = its_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* design/its_datapath.sv */
// ----------------------------------------------------------------------------
// its_datapath: alphabet store, radix divider, digit buffer, output register
// The divider resolves DIV_STEPS quotient bits per pass by restoring
// subtraction against the alphabet length; the remainder indexes the table.
// ----------------------------------------------------------------------------
module its_datapath #(
    parameter int MAX_ALPHABET = 128,
    parameter int NUMBER_BITS  = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  its_pkg::cmd_t               cmd,
    output its_pkg::sts_t               sts,
    input  logic [39:0]                 s_tdata,
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [its_pkg::CHAR_W-1:0]  out_char,
    output logic                        out_last,
    output logic                        out_status
);

    localparam int TBL_AW = (MAX_ALPHABET > 1) ? $clog2(MAX_ALPHABET) : 1;
    localparam int PASSES = (NUMBER_BITS + its_pkg::DIV_STEPS - 1) / its_pkg::DIV_STEPS;
    localparam int DIV_W  = PASSES * its_pkg::DIV_STEPS;
    localparam int PASS_W = (PASSES > 1) ? $clog2(PASSES) : 1;
    localparam int LW     = its_pkg::LEN_W;
    localparam int CW     = its_pkg::CHAR_W;
    localparam int NW     = its_pkg::ND_W;

    // alphabet state
    logic [LW-1:0]           len_reg;
    logic                    bad_reg;
    logic                    valid_reg;
    logic                    open_reg;
    logic [127:0]            seen_reg;
    logic [CW-1:0]           digit_table_mem [MAX_ALPHABET];
    logic [CW-1:0]           tbl_rd_reg;

    // captured input
    logic [7:0]              ch_reg;
    logic                    last_reg;
    logic                    neg_reg;

    // divider and digit buffer
    logic [DIV_W-1:0]        div_reg;
    logic [CW-1:0]           rem_reg;
    logic [PASS_W-1:0]       pass_reg;
    logic [NW-1:0]           nd_reg;
    logic [CW-1:0]           digit_buf_reg [its_pkg::DIGIT_DEPTH];

    // output register
    logic                    m_tvalid_reg;
    logic [CW-1:0]           out_char_reg;
    logic                    out_last_reg;
    logic                    out_status_reg;

    // input decode
    logic [NUMBER_BITS-1:0]  num_in;
    logic                    neg_in;
    logic [NUMBER_BITS-1:0]  mag_in;

    // load checks
    logic [127:0]            seen_eff;
    logic [LW-1:0]           len_eff;
    logic                    bad_eff;
    logic                    char_bad;
    logic                    reject;
    logic                    take_char;
    logic [LW-1:0]           len_new;
    logic                    bad_new;
    logic [127:0]            seen_new;

    logic [DIV_W-1:0]        div_step_q;
    logic [CW-1:0]           rem_step;
    logic [NW-1:0]           nd_dec;
    logic                    out_free;

    assign num_in = s_tdata[8 +: NUMBER_BITS];
    assign neg_in = num_in[NUMBER_BITS-1];
    assign mag_in = neg_in ? NUMBER_BITS'(~num_in + 1'b1) : num_in;

    // a load beat with no load open starts from an empty alphabet
    assign seen_eff = open_reg ? seen_reg : '0;
    assign len_eff  = open_reg ? len_reg  : '0;
    assign bad_eff  = open_reg ? bad_reg  : 1'b0;

    assign char_bad  = (ch_reg == its_pkg::CHAR_PLUS) || (ch_reg == its_pkg::CHAR_MINUS)
                    || (ch_reg <= its_pkg::CHAR_SPACE) || (ch_reg >= its_pkg::CHAR_DEL);
    assign reject    = char_bad || seen_eff[ch_reg[6:0]] || (len_eff >= LW'(MAX_ALPHABET));
    assign take_char = !bad_eff && !reject;
    assign bad_new   = bad_eff || reject;
    assign len_new   = len_eff + LW'(take_char);
    assign seen_new  = seen_eff | (take_char ? (128'(1) << ch_reg[6:0]) : '0);

    // restoring division, DIV_STEPS bits per pass
    always_comb begin
        logic [CW-1:0]    r;
        logic [DIV_W-1:0] d;
        logic [CW:0]      t;
        r = rem_reg;
        d = div_reg;
        for (int i = 0; i < its_pkg::DIV_STEPS; i++) begin
            t = {r, d[DIV_W-1]};
            d = {d[DIV_W-2:0], 1'b0};
            if (t >= len_reg) begin
                r    = CW'(t - len_reg);
                d[0] = 1'b1;
            end else begin
                r = t[CW-1:0];
            end
        end
        div_step_q = d;
        rem_step   = r;
    end

    assign nd_dec   = nd_reg - NW'(1);
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg      <= '0;
            bad_reg      <= 1'b0;
            valid_reg    <= 1'b0;
            open_reg     <= 1'b0;
            seen_reg     <= '0;
            pass_reg     <= '0;
            nd_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                len_reg   <= len_new;
                bad_reg   <= bad_new;
                seen_reg  <= seen_new;
                open_reg  <= !last_reg;
                valid_reg <= last_reg && !bad_new && (len_new >= LW'(2));
            end
            if (cmd.accept) begin
                pass_reg <= '0;
                nd_reg   <= '0;
            end
            if (cmd.div_step) begin
                pass_reg <= sts.div_last ? '0 : pass_reg + PASS_W'(1);
            end
            if (cmd.store) begin
                nd_reg <= nd_reg + NW'(1);
            end
            if (cmd.emit_digit) begin
                nd_reg <= nd_dec;
            end
            if (cmd.emit_sign || cmd.emit_digit || cmd.emit_err) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        tbl_rd_reg <= digit_table_mem[rem_reg[TBL_AW-1:0]];
        if (cmd.load && take_char) begin
            digit_table_mem[len_eff[TBL_AW-1:0]] <= ch_reg[CW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            ch_reg   <= s_tdata[7:0];
            last_reg <= s_tlast;
            neg_reg  <= neg_in;
            div_reg  <= DIV_W'(mag_in);
            rem_reg  <= '0;
        end
        if (cmd.div_step) begin
            div_reg <= div_step_q;
            rem_reg <= rem_step;
        end
        if (cmd.store) begin
            digit_buf_reg[nd_reg[its_pkg::BUF_AW-1:0]] <= tbl_rd_reg;
            rem_reg <= '0;
        end
        if (cmd.emit_sign) begin
            out_char_reg   <= CW'(its_pkg::CHAR_MINUS);
            out_last_reg   <= 1'b0;
            out_status_reg <= its_pkg::STATUS_OK;
        end
        if (cmd.emit_digit) begin
            out_char_reg   <= digit_buf_reg[nd_dec[its_pkg::BUF_AW-1:0]];
            out_last_reg   <= sts.emit_last;
            out_status_reg <= its_pkg::STATUS_OK;
        end
        if (cmd.emit_err) begin
            out_char_reg   <= '0;
            out_last_reg   <= 1'b1;
            out_status_reg <= its_pkg::STATUS_BAD;
        end
    end

    assign sts.alph_valid  = valid_reg;
    assign sts.div_last    = (pass_reg == PASS_W'(PASSES - 1));
    assign sts.digits_done = (div_reg == '0) || (nd_reg == NW'(its_pkg::DIGIT_DEPTH - 1));
    assign sts.neg         = neg_reg;
    assign sts.out_free    = out_free;
    assign sts.emit_last   = (nd_reg == NW'(1));

    assign m_tvalid   = m_tvalid_reg;
    assign out_char   = out_char_reg;
    assign out_last   = out_last_reg;
    assign out_status = out_status_reg;

endmodule

/* design/int_to_radix_string_top.sv */
// Flow: a load beat is accepted, then checked and stored in ST_LOAD; a convert
//   with no valid alphabet is accepted and gives its error beat from ST_ERR.
// A convert extracts each digit through ST_DIV, ST_LOOK and ST_STORE
//   (shared 8-bit-per-cycle divider plus table read), then streams its beats out.
// One item is in work at a time; throughput follows the conversion length.
// Reset (aresetn low, synchronous) empties the alphabet and the output register.
// ----------------------------------------------------------------------------
// int_to_radix_string_top: signed integer to string in a loaded radix
// Load beats build a checked digit alphabet; convert beats stream out an
// optional minus sign and the digits, most significant first, or an error beat.
// ----------------------------------------------------------------------------
module int_to_radix_string_top #(
    parameter int MAX_ALPHABET = 128,
    parameter int NUMBER_BITS  = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // alphabet_char[7:0], number[39:8]
    input  logic        s_tuser,   // req_type
    input  logic        s_tlast,   // alphabet_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_char[6:0], zero pad[7]
    output logic        m_tuser,   // out_status
    output logic        m_tlast    // out_last
);

    its_pkg::cmd_t             cmd;
    its_pkg::sts_t             sts;
    logic [its_pkg::CHAR_W-1:0] out_char;

    its_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    its_datapath #(
        .MAX_ALPHABET (MAX_ALPHABET),
        .NUMBER_BITS  (NUMBER_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .out_char   (out_char),
        .out_last   (m_tlast),
        .out_status (m_tuser)
    );

    assign m_tdata = {1'b0, out_char};

    // every accepted beat leaves the block busy, so no two beats are taken back to back
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted back to back");

    a_err_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("error beat not flagged last");

    a_char_printable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (m_tdata[6:0] >= 7'd33) && (m_tdata[6:0] <= 7'd126))
        else $error("emitted character outside printable range");

endmodule

/* verif/its_stream_checker.sv */
// ----------------------------------------------------------------------------
// its_stream_checker: output predictor and comparator for int_to_radix_string
// Watches both stream channels. Load beats rebuild the digit alphabet in a
// local copy; convert beats are spelled out into the expected output beats,
// which are matched in order against every beat taken from the master side.
// ----------------------------------------------------------------------------
module its_stream_checker #(
    parameter int MAX_ALPHABET = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic        s_tuser,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    output int          errors,
    output int          pending
);

    typedef struct packed {
        logic [its_pkg::CHAR_W-1:0] ch;
        logic                       last;
        logic                       status;
    } char_beat_t;

    char_beat_t                 char_q[$];
    logic [its_pkg::CHAR_W-1:0] digit_table[128];
    logic                       seen[128];
    int                         alpha_len;
    logic                       alpha_bad;
    logic                       alpha_ok;
    logic                       load_open;

    initial begin
        errors  = 0;
        pending = 0;
    end

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    task automatic absorb_char(input logic [7:0] ch, input logic last);
        if (!load_open) begin
            foreach (seen[i]) seen[i] = 1'b0;
            alpha_len = 0;
            alpha_bad = 1'b0;
            alpha_ok  = 1'b0;
            load_open = 1'b1;
        end
        if (!alpha_bad) begin
            if (ch == its_pkg::CHAR_PLUS || ch == its_pkg::CHAR_MINUS
                || ch <= its_pkg::CHAR_SPACE || ch >= its_pkg::CHAR_DEL)
                alpha_bad = 1'b1;
            else if (seen[ch[6:0]])
                alpha_bad = 1'b1;
            else if (alpha_len >= MAX_ALPHABET)
                alpha_bad = 1'b1;
            else begin
                seen[ch[6:0]] = 1'b1;
                digit_table[alpha_len[6:0]] = ch[6:0];
                alpha_len++;
            end
        end
        if (last) begin
            load_open = 1'b0;
            alpha_ok  = !alpha_bad && alpha_len >= 2;
        end
    endtask

    task automatic spell_number(input logic [31:0] num);
        logic [31:0]                mag;
        logic [31:0]                radix;
        logic [its_pkg::CHAR_W-1:0] digits[32];
        int                         nd;
        if (!alpha_ok || alpha_len < 2) begin
            char_q.push_back('{ch: '0, last: 1'b1, status: its_pkg::STATUS_BAD});
            return;
        end
        radix = alpha_len;
        mag   = num[31] ? (~num + 32'd1) : num;
        nd    = 0;
        do begin
            digits[5'(nd)] = digit_table[7'(mag % radix)];
            mag = mag / radix;
            nd++;
        end while (mag != 0 && nd < 32);
        if (num[31])
            char_q.push_back('{ch: its_pkg::CHAR_W'(its_pkg::CHAR_MINUS), last: 1'b0,
                               status: its_pkg::STATUS_OK});
        for (int i = nd - 1; i >= 0; i--)
            char_q.push_back('{ch: digits[5'(i)], last: (i == 0),
                               status: its_pkg::STATUS_OK});
    endtask

    always @(posedge aclk) begin
        char_beat_t want;
        if (!aresetn) begin
            char_q.delete();
            foreach (seen[i]) seen[i] = 1'b0;
            alpha_len = 0;
            alpha_bad = 1'b0;
            alpha_ok  = 1'b0;
            load_open = 1'b0;
        end else begin
            // compare first: a beat out at this edge never belongs to a beat in now
            if (m_tvalid && m_tready) begin
                if (char_q.size() == 0) begin
                    report($sformatf("unexpected beat data=%h last=%b status=%b",
                                     m_tdata, m_tlast, m_tuser));
                end else begin
                    want = char_q.pop_front();
                    if (m_tdata !== {1'b0, want.ch})
                        report($sformatf("char got %h want %h", m_tdata, want.ch));
                    if (m_tlast !== want.last)
                        report($sformatf("last got %b want %b", m_tlast, want.last));
                    if (m_tuser !== want.status)
                        report($sformatf("status got %b want %b", m_tuser, want.status));
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == its_pkg::REQ_LOAD)
                    absorb_char(s_tdata[7:0], s_tlast);
                else
                    spell_number(s_tdata[39:8]);
            end
        end
        pending <= char_q.size();
    end

endmodule

/* verif/int_to_radix_string_top_tb.sv */
// ----------------------------------------------------------------------------
// int_to_radix_string_top_tb: stimulus and verdict for int_to_radix_string_top
// Loads good and broken alphabets of random radix, converts edge and random
// numbers, and randomly throttles both channels. Checking sits in a separate
// stream checker; a watchdog ends the run when traffic stops.
// ----------------------------------------------------------------------------
module int_to_radix_string_top_tb;

    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE      = 300;
    localparam int ITEM_TARGET = 190;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // alphabet_char[7:0], number[39:8]
    logic        s_tuser;   // req_type
    logic        s_tlast;   // alphabet_last
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // out_char[6:0], zero pad[7]
    logic        m_tuser;   // out_status
    logic        m_tlast;   // out_last

    int          errors;
    int          pending;
    int          quiet;
    int          items_sent;
    int          send_calm;
    int          take_calm;
    logic [7:0]  pool[92];
    logic [7:0]  load_seq[$];

    int_to_radix_string_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    its_stream_checker watch (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .errors   (errors),
        .pending  (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // gap before the next beat; now and then a run of back-to-back beats
    function automatic int draw_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            calm = $urandom_range(8, 30);
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    function automatic logic [31:0] rand_number();
        logic [31:0] v;
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4, 5: begin
                v = $urandom_range(0, 1000);
                return $urandom_range(0, 1) ? -v : v;
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic send_beat(input logic req, input logic [7:0] ch, input logic last,
                             input logic [31:0] num);
        int gap;
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tlast  <= last;
        s_tdata  <= {num, ch};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic load_one(input logic [7:0] ch, input logic last);
        send_beat(its_pkg::REQ_LOAD, ch, last, $urandom);
    endtask

    task automatic convert(input logic [31:0] num);
        send_beat(its_pkg::REQ_CONVERT, 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), num);
    endtask

    task automatic send_load_seq();
        foreach (load_seq[i]) load_one(load_seq[i], i == load_seq.size() - 1);
    endtask

    // hold the sender until every predicted beat has come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic shuffle_pool();
        logic [7:0] t;
        int         j;
        for (int i = 91; i > 0; i--) begin
            j           = $urandom_range(0, i);
            t           = pool[7'(i)];
            pool[7'(i)] = pool[7'(j)];
            pool[7'(j)] = t;
        end
    endtask

    // result side: random stalls between beats
    initial begin
        int gap;
        m_tready = 1'b0;
        take_calm = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = draw_gap(take_calm);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int          k;
        int          radix;
        int          n;
        int          p;
        int          pick;
        logic [7:0]  bad_ch;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tuser    = 1'b0;
        s_tlast    = 1'b0;
        s_tdata    = '0;
        quiet      = 0;
        items_sent = 0;
        send_calm  = 0;
        k = 0;
        for (int c = 33; c <= 126; c++) begin
            if (c != its_pkg::CHAR_PLUS && c != its_pkg::CHAR_MINUS) begin
                pool[7'(k)] = 8'(c);
                k++;
            end
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part
        convert(32'd0);                    // nothing loaded yet
        load_one("0", 1'b0);
        load_one("1", 1'b1);
        convert(32'd0);
        convert(32'h8000_0000);            // most negative, 32 binary digits
        convert(32'h7FFF_FFFF);
        convert(32'hFFFF_FFFF);
        load_one("Z", 1'b0);
        convert(32'd5);                    // load still open
        load_one("+", 1'b1);
        convert(32'd7);
        load_one("A", 1'b1);               // one character only
        convert(32'd3);
        load_one(its_pkg::CHAR_SPACE, 1'b0);
        load_one("B", 1'b1);
        load_one("a", 1'b0);
        load_one(8'hFF, 1'b1);
        load_one("q", 1'b0);
        load_one("q", 1'b1);               // repeat
        load_one(its_pkg::CHAR_DEL, 1'b1);
        load_one(its_pkg::CHAR_MINUS, 1'b1);
        convert(32'd9);
        wait_drained();

        // random part
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 3) == 0)
                wait_drained();
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                pick  = $urandom_range(0, 9);
                radix = pick < 7 ? $urandom_range(2, 16) :
                        pick < 9 ? $urandom_range(17, 91) : 92;
                shuffle_pool();
                for (int i = 0; i < radix; i++) begin
                    if (i > 0 && $urandom_range(0, 19) == 0)
                        convert(rand_number());
                    load_one(pool[7'(i)], i == radix - 1);
                end
                repeat ($urandom_range(3, 8)) convert(rand_number());
            end else if (pick < 9) begin
                shuffle_pool();
                n = $urandom_range(1, 6);
                p = $urandom_range(0, n);
                load_seq.delete();
                case ($urandom_range(0, 5))
                    0: bad_ch = its_pkg::CHAR_PLUS;
                    1: bad_ch = its_pkg::CHAR_MINUS;
                    2: bad_ch = 8'($urandom_range(0, 32));
                    3: bad_ch = 8'($urandom_range(127, 255));
                    4: bad_ch = (p > 0) ? pool[7'($urandom_range(0, p - 1))]
                                        : its_pkg::CHAR_PLUS;
                    default: begin
                        bad_ch = pool[0];
                        n = 0;
                        p = 0;
                    end
                endcase
                for (int i = 0; i <= n; i++)
                    load_seq.push_back(i == p ? bad_ch : pool[7'(i)]);
                send_load_seq();
                repeat ($urandom_range(1, 2)) convert(rand_number());
            end else begin
                repeat ($urandom_range(1, 3)) convert(rand_number());
            end
        end

        wait_drained();
        repeat (SETTLE) @(posedge aclk);
        if (errors == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
